@@ design/modexp_pkg.sv @@
package modexp_pkg;

  // Field widths
  localparam int MOD_BITS = 31;
  localparam int EXP_BITS = 32;

  // Counter widths for the bit loops
  localparam int MOD_CNT_W = $clog2(MOD_BITS);
  localparam int EXP_CNT_W = $clog2(EXP_BITS);

  // Modulus after reset: 1e9 + 7
  localparam logic [MOD_BITS-1:0] MODULUS_RESET = MOD_BITS'(1000000007);

  // Command to the modular multiply unit
  typedef struct packed {
    logic                start;
    logic                reduce;  // reduce b modulo m instead of a*b mod m
    logic [MOD_BITS-1:0] a;
    logic [MOD_BITS-1:0] b;
  } mm_req_t;

  // Answer from the modular multiply unit
  typedef struct packed {
    logic                done;
    logic [MOD_BITS-1:0] res;
  } mm_rsp_t;

  // Sequencer states
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RED  = 5'b00010,
    S_SQR  = 5'b00100,
    S_MUL  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

endpackage

@@ design/modexp_mulmod.sv @@
module modexp_mulmod (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [modexp_pkg::MOD_BITS-1:0] modulus,
  input  modexp_pkg::mm_req_t            req,
  output modexp_pkg::mm_rsp_t            rsp
);

  localparam int W = modexp_pkg::MOD_BITS;

  logic [W-1:0]                     r_r, r_nxt;
  logic [W-1:0]                     sh_r, sh_nxt;
  logic [W-1:0]                     a_r, a_nxt;
  logic                             reduce_r, reduce_nxt;
  logic [modexp_pkg::MOD_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                             busy_r, busy_nxt;
  logic                             done_r, done_nxt;

  logic         bit_in;
  logic [W:0]   m_ext;
  logic [W:0]   t0, t1, t2, t3;

  // Step: double (shift bit in if reducing), reduce, else add a if set, reduce
  always_comb begin
    bit_in = sh_r[W-1];
    m_ext  = {1'b0, modulus};
    t0     = {r_r, (reduce_r & bit_in)};
    t1     = (t0 >= m_ext) ? (t0 - m_ext) : t0;
    t2     = t1 + ((!reduce_r && bit_in) ? {1'b0, a_r} : '0);
    t3     = (t2 >= m_ext) ? (t2 - m_ext) : t2;
  end

  // Load a command, then walk the multiplier bits from the top
  always_comb begin
    r_nxt      = r_r;
    sh_nxt     = sh_r;
    a_nxt      = a_r;
    reduce_nxt = reduce_r;
    cnt_nxt    = cnt_r;
    busy_nxt   = busy_r;
    done_nxt   = 1'b0;
    if (busy_r) begin
      r_nxt   = t3[W-1:0];
      sh_nxt  = {sh_r[W-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == modexp_pkg::MOD_CNT_W'(W-1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (req.start) begin
      r_nxt      = '0;
      sh_nxt     = req.b;
      a_nxt      = req.a;
      reduce_nxt = req.reduce;
      cnt_nxt    = '0;
      busy_nxt   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    r_r      <= r_nxt;
    sh_r     <= sh_nxt;
    a_r      <= a_nxt;
    reduce_r <= reduce_nxt;
    cnt_r    <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.res  = r_r;

endmodule

@@ design/modexp_seq.sv @@
module modexp_seq (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [modexp_pkg::MOD_BITS-1:0] modulus,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [modexp_pkg::MOD_BITS-1:0] in_base,
  input  logic [modexp_pkg::EXP_BITS-1:0] in_exponent,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [modexp_pkg::MOD_BITS-1:0] out_power,
  output modexp_pkg::mm_req_t             req,
  input  modexp_pkg::mm_rsp_t             rsp
);

  localparam int MW = modexp_pkg::MOD_BITS;
  localparam int EW = modexp_pkg::EXP_BITS;

  modexp_pkg::state_t               state_r, state_nxt;
  logic [MW-1:0]                    acc_r, acc_nxt;
  logic [MW-1:0]                    base_r, base_nxt;
  logic [EW-1:0]                    exp_r, exp_nxt;
  logic [modexp_pkg::EXP_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                             start_r, start_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic [MW-1:0]                    power_r, power_nxt;

  // Step the exponent bit loop
  always_comb begin
    state_nxt     = state_r;
    acc_nxt       = acc_r;
    base_nxt      = base_r;
    exp_nxt       = exp_r;
    cnt_nxt       = cnt_r;
    start_nxt     = 1'b0;
    out_valid_nxt = out_valid_r;
    power_nxt     = power_r;

    // Drop the result once it is taken
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      modexp_pkg::S_IDLE: begin
        if (in_valid) begin
          base_nxt = in_base;
          exp_nxt  = in_exponent;
          cnt_nxt  = '0;
          if (modulus < MW'(2)) begin
            acc_nxt   = '0;
            state_nxt = modexp_pkg::S_DONE;
          end else begin
            acc_nxt   = MW'(1);
            state_nxt = modexp_pkg::S_RED;
            start_nxt = 1'b1;
          end
        end
      end
      modexp_pkg::S_RED: begin
        if (rsp.done) begin
          base_nxt  = rsp.res;
          state_nxt = modexp_pkg::S_SQR;
          start_nxt = 1'b1;
        end
      end
      modexp_pkg::S_SQR, modexp_pkg::S_MUL: begin
        if (rsp.done) begin
          acc_nxt = rsp.res;
          if (state_r == modexp_pkg::S_SQR && exp_r[EW-1]) begin
            state_nxt = modexp_pkg::S_MUL;
            start_nxt = 1'b1;
          end else if (cnt_r == modexp_pkg::EXP_CNT_W'(EW-1)) begin
            state_nxt = modexp_pkg::S_DONE;
          end else begin
            cnt_nxt   = cnt_r + 1'b1;
            exp_nxt   = {exp_r[EW-2:0], 1'b0};
            state_nxt = modexp_pkg::S_SQR;
            start_nxt = 1'b1;
          end
        end
      end
      modexp_pkg::S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          power_nxt     = acc_r;
          state_nxt     = modexp_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = modexp_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    acc_r   <= acc_nxt;
    base_r  <= base_nxt;
    exp_r   <= exp_nxt;
    cnt_r   <= cnt_nxt;
    power_r <= power_nxt;
    if (!rst_n) begin
      state_r     <= modexp_pkg::S_IDLE;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      start_r     <= start_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Pick the operands of the shared unit by phase
  always_comb begin
    req.start  = start_r;
    req.reduce = 1'b0;
    req.a      = acc_r;
    req.b      = acc_r;
    case (state_r)
      modexp_pkg::S_RED: begin
        req.reduce = 1'b1;
        req.a      = '0;
        req.b      = base_r;
      end
      modexp_pkg::S_MUL: begin
        req.b = base_r;
      end
      default: begin
        req.reduce = 1'b0;
      end
    endcase
  end

  assign in_stall  = (state_r != modexp_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_power = power_r;

endmodule

@@ design/modular_exponentiation.sv @@
// Modular exponentiation: each item (in_base, in_exponent) returns
// out_power = in_base ^ in_exponent mod modulus, with the base reduced modulo
// the modulus first and an exponent of zero giving 1; a modulus of 0 or 1
// gives 0. The modulus resets to 1000000007; the user must write it through
// cfg_wr_en / cfg_wr_data only while no item is in flight, which the block
// itself does not enforce. One item is worked on at a time: a single
// bit-serial modular multiply unit (one bit per cycle) first reduces the base,
// then squares for each of the 32 exponent bits and multiplies once more for
// each set bit. A modulus below two skips the multiply unit and goes straight
// to the done state. The input stalls for the whole computation; the result
// waits in an output register.
module modular_exponentiation (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [modexp_pkg::MOD_BITS-1:0] cfg_wr_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [modexp_pkg::MOD_BITS-1:0] in_base,
  input  logic [modexp_pkg::EXP_BITS-1:0] in_exponent,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [modexp_pkg::MOD_BITS-1:0] out_power
);

  logic [modexp_pkg::MOD_BITS-1:0] modulus_r, modulus_nxt;
  modexp_pkg::mm_req_t             mm_req;
  modexp_pkg::mm_rsp_t             mm_rsp;

  // Hold the modulus register
  always_comb begin
    modulus_nxt = modulus_r;
    if (cfg_wr_en) begin
      modulus_nxt = cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= modexp_pkg::MODULUS_RESET;
    end else begin
      modulus_r <= modulus_nxt;
    end
  end

  modexp_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .modulus     (modulus_r),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_base     (in_base),
    .in_exponent (in_exponent),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_power   (out_power),
    .req         (mm_req),
    .rsp         (mm_rsp)
  );

  modexp_mulmod u_mulmod (
    .clk     (clk),
    .rst_n   (rst_n),
    .modulus (modulus_r),
    .req     (mm_req),
    .rsp     (mm_rsp)
  );

endmodule

@@ test/tb_top.sv @@
typedef logic [modexp_pkg::MOD_BITS-1:0] mod_word_t;
typedef logic [modexp_pkg::EXP_BITS-1:0] exp_word_t;

// One power in flight, with the operands it came from
typedef struct packed {
  mod_word_t base;
  exp_word_t exponent;
  mod_word_t modulus;
  mod_word_t power;
} power_entry_t;

class power_scoreboard;
  mod_word_t    modulus;
  power_entry_t pending_powers[$];
  int           mismatches;

  function new();
    modulus    = modexp_pkg::MODULUS_RESET;
    mismatches = 0;
  endfunction

  function void set_modulus(mod_word_t value);
    modulus = value;
  endfunction

  function int pending();
    return pending_powers.size();
  endfunction

  // Square and multiply over the exponent bits, most significant first
  function mod_word_t predict_power(mod_word_t b, exp_word_t e);
    logic [63:0] m;
    logic [63:0] acc;
    logic [63:0] reduced_base;
    int          i;
    if (modulus < 2) return '0;
    m            = 64'(modulus);
    reduced_base = 64'(b) % m;
    acc          = 64'd1;
    for (i = modexp_pkg::EXP_BITS - 1; i >= 0; i--) begin
      acc = (acc * acc) % m;
      if (e[i]) acc = (acc * reduced_base) % m;
    end
    return mod_word_t'(acc);
  endfunction

  // Queue the expected power for an accepted item
  function void note_item(mod_word_t b, exp_word_t e);
    power_entry_t entry;
    entry.base     = b;
    entry.exponent = e;
    entry.modulus  = modulus;
    entry.power    = predict_power(b, e);
    pending_powers.push_back(entry);
  endfunction

  // Compare an accepted result against the oldest expected power
  function void check_power(mod_word_t actual);
    power_entry_t want;
    if (pending_powers.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected power %0d with no item pending", actual);
      return;
    end
    want = pending_powers.pop_front();
    if (actual !== want.power) begin
      mismatches++;
      if (mismatches <= 10)
        $display("power mismatch: base=%0d exponent=%0d modulus=%0d expected %0d, got %0d",
                 want.base, want.exponent, want.modulus, want.power, actual);
    end
  endfunction
endclass

module tb_top;
  localparam int unsigned QUIET_LIMIT = 20000;
  localparam int unsigned TAIL_CYCLES = 2200;
  localparam mod_word_t   MAX_BASE    = '1;
  localparam exp_word_t   MAX_EXP     = '1;

  logic      clk         = 1'b0;
  logic      rst_n       = 1'b0;
  logic      cfg_wr_en   = 1'b0;
  mod_word_t cfg_wr_data = '0;
  logic      in_valid    = 1'b0;
  logic      in_stall;
  mod_word_t in_base     = '0;
  exp_word_t in_exponent = '0;
  logic      out_valid;
  logic      out_stall   = 1'b0;
  mod_word_t out_power;

  logic        stall_on     = 1'b1;
  int unsigned stall_left   = 0;
  int unsigned quiet_cycles = 0;

  power_scoreboard board = new();

  modular_exponentiation u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_base     (in_base),
    .in_exponent (in_exponent),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_power   (out_power)
  );

  always #4 clk = ~clk;

  // Check accepted results and stall the output in random bursts
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_power(out_power);
    if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (stall_on && $urandom_range(0, out_valid ? 2 : 15) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 7);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Count cycles in which no item, result or register write moves
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("TB_ERROR");
    $finish;
  end

  // Present one item, hold it until accepted, then maybe drop valid for a while
  task automatic send_item(input mod_word_t b, input exp_word_t e, input bit allow_gap);
    in_valid    <= 1'b1;
    in_base     <= b;
    in_exponent <= e;
    do @(posedge clk); while (in_stall);
    board.note_item(b, e);
    if (allow_gap && $urandom_range(0, 1) == 1) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  // Hold off the sender until every expected power has come back
  task automatic drain_powers();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  // Drain, then write the modulus while the block is idle
  task automatic write_modulus(input mod_word_t value);
    drain_powers();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    board.set_modulus(value);
  endtask

  // Mix full-range, small, near-modulus and extreme operands
  task automatic pick_operands(output mod_word_t b, output exp_word_t e);
    int unsigned base_kind;
    int unsigned exp_kind;
    base_kind = $urandom_range(0, 9);
    exp_kind  = $urandom_range(0, 9);
    if (base_kind <= 4)
      b = mod_word_t'($urandom);
    else if (base_kind <= 6)
      b = mod_word_t'($urandom_range(0, 15));
    else if (base_kind == 7)
      b = board.modulus - mod_word_t'(1) + mod_word_t'($urandom_range(0, 2));
    else if (base_kind == 8)
      b = board.modulus * mod_word_t'($urandom_range(1, 3));
    else
      b = $urandom_range(0, 1) ? MAX_BASE : '0;
    if (exp_kind <= 5)
      e = exp_word_t'($urandom);
    else if (exp_kind <= 7)
      e = exp_word_t'($urandom_range(0, 20));
    else if (exp_kind == 8)
      e = $urandom_range(0, 1) ? MAX_EXP : '0;
    else
      e = exp_word_t'(1) << $urandom_range(0, modexp_pkg::EXP_BITS - 1);
  endtask

  initial begin
    mod_word_t   b;
    exp_word_t   e;
    mod_word_t   phase_modulus;
    int unsigned phase_items;
    bit          last_phase;
    int          p;
    int          k;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset modulus, zero exponent, base at or above the modulus
    send_item('0, '0, 1'b1);
    send_item('0, 32'd5, 1'b1);
    send_item(31'd1, MAX_EXP, 1'b1);
    send_item(MAX_BASE, '0, 1'b1);
    send_item(MAX_BASE, 32'd1, 1'b1);
    send_item(MAX_BASE, MAX_EXP, 1'b1);
    send_item(31'd1000000007, 32'd3, 1'b1);
    send_item(31'd1000000006, 32'd2, 1'b1);
    send_item(31'd2, 32'd30, 1'b1);
    send_item(31'd12345, 32'h8000_0000, 1'b1);
    send_item(mod_word_t'($urandom), 32'd1, 1'b1);

    // Directed: largest modulus
    write_modulus(31'h7FFF_FFFF);
    send_item(31'h7FFF_FFFE, MAX_EXP, 1'b1);
    send_item('0, '0, 1'b1);
    send_item(MAX_BASE, 32'd7, 1'b1);
    send_item(31'd3, 32'h5555_5555, 1'b1);

    // Directed: smallest valid modulus
    write_modulus(31'd2);
    send_item('0, '0, 1'b1);
    send_item(31'd1, MAX_EXP, 1'b1);
    send_item(MAX_BASE, 32'd2, 1'b1);
    send_item(31'd2, 32'd1, 1'b1);

    // Directed: modulus below two gives zero, even for a zero exponent
    write_modulus(31'd1);
    send_item('0, '0, 1'b1);
    send_item(31'd7, 32'd9, 1'b1);
    write_modulus('0);
    send_item('0, '0, 1'b1);
    send_item(MAX_BASE, MAX_EXP, 1'b1);

    // Random phases, each under its own modulus
    for (p = 0; p < 8; p++) begin
      last_phase  = (p == 7);
      phase_items = 35;
      case (p)
        0: phase_modulus = 31'h7FFF_FFFF;
        1: phase_modulus = mod_word_t'($urandom_range(3, 255));
        2: phase_modulus = mod_word_t'($urandom_range(2, 32'h7FFF_FFFF));
        3: phase_modulus = 31'd2;
        4: begin
          phase_modulus = mod_word_t'($urandom_range(0, 1));
          phase_items   = 10;
        end
        5: phase_modulus = modexp_pkg::MODULUS_RESET;
        6: phase_modulus = mod_word_t'($urandom_range(2, 65535));
        default: phase_modulus = mod_word_t'($urandom_range(2, 32'h7FFF_FFFF));
      endcase
      write_modulus(phase_modulus);
      if (last_phase) stall_on <= 1'b0;
      for (k = 0; k < phase_items; k++) begin
        pick_operands(b, e);
        send_item(b, e, !last_phase);
      end
    end

    // Wait out every expected power, then the block's latency
    drain_powers();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (board.mismatches == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end
endmodule
